FILE: src/adc_moving_average_bar_level_defines.svh
// assertion macros for the adc moving average bar level block
// no dependencies; included by the files that carry assertions
`ifndef ADC_MOVING_AVERAGE_BAR_LEVEL_DEFINES_SVH
`define ADC_MOVING_AVERAGE_BAR_LEVEL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ADCMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adcma assertion failed");

// next-cycle implication, checked out of reset
`define ADCMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adcma assertion failed");

`endif

FILE: src/adcma_pkg.sv
// shared widths, constants and types of the adc moving average bar level block
// no dependencies
package adcma_pkg;

  localparam int unsigned RAW_W     = 16;
  localparam int unsigned ADC_BITS  = 10;
  localparam int unsigned MV_W      = 12;
  localparam int unsigned THR_W     = 12;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned X_W       = 22;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MV_MAX    = 3000;

  localparam logic [RAW_W-1:0] ADC_MAX       = 16'd1023;
  localparam logic [X_W-1:0]   FULL_SCALE_MV = 22'd3000;
  localparam logic [MV_W-1:0]  MV_RESET      = 12'd100;

  localparam logic [THR_W-1:0] THR_LOW_RESET  = 12'd1000;
  localparam logic [THR_W-1:0] THR_MID_RESET  = 12'd2000;
  localparam logic [THR_W-1:0] THR_HIGH_RESET = 12'd3000;

  localparam logic [MASK_W-1:0] MASK_FOUR  = 4'hF;
  localparam logic [MASK_W-1:0] MASK_THREE = 4'h7;
  localparam logic [MASK_W-1:0] MASK_TWO   = 4'h3;
  localparam logic [MASK_W-1:0] MASK_ONE   = 4'h1;

  localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0] low;
    logic [THR_W-1:0] mid;
    logic [THR_W-1:0] high;
  } thr_t;

endpackage

FILE: src/adc_moving_average_bar_level.sv
// top level of the adc moving average bar level block: threshold registers and pipeline
// depends on adcma_pkg, adcma_conv, adcma_ring, adcma_bar and the defines header
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid / in_stall | in_raw_sample, in_read_failed
//   out     | output    | out_valid/out_stall | out_average_millivolts, out_led_mask
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// one word accepted per cycle while in_stall is low; a result is registered through the conv, ring and bar stages
// the first PRIOR_SAMPLES words after reset fill the history and give no result
// every stage holds on its own; in_stall rises only when all stages up to the input are full
// synchronous active-low reset clears the stage valids, fill count and sum, and loads the reset thresholds
`include "adc_moving_average_bar_level_defines.svh"

module adc_moving_average_bar_level import adcma_pkg::*; #(
  parameter int unsigned PRIOR_SAMPLES = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RAW_W-1:0]     in_raw_sample,
  input  logic                 in_read_failed,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MV_W-1:0]      out_average_millivolts,
  output logic [MASK_W-1:0]    out_led_mask,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  localparam int unsigned TOT_W = $clog2((PRIOR_SAMPLES + 1) * MV_MAX + 1);

  thr_t             thr_r;
  logic             in_ready;
  logic             cv_valid, cv_ready;
  logic [MV_W-1:0]  cv_cur;
  logic             rg_valid, rg_ready;
  logic [TOT_W-1:0] rg_total;
  logic             cfg_low_we;
  logic             mask_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.low  <= THR_LOW_RESET;
      thr_r.mid  <= THR_MID_RESET;
      thr_r.high <= THR_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THR_LOW:  thr_r.low  <= cfg_data;
        CFG_THR_MID:  thr_r.mid  <= cfg_data;
        CFG_THR_HIGH: thr_r.high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  adcma_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (in_valid),
    .s_ready  (in_ready),
    .s_raw    (in_raw_sample),
    .s_failed (in_read_failed),
    .m_valid  (cv_valid),
    .m_ready  (cv_ready),
    .m_cur    (cv_cur)
  );

  adcma_ring #(
    .PRIOR_SAMPLES (PRIOR_SAMPLES)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (cv_valid),
    .s_ready (cv_ready),
    .s_cur   (cv_cur),
    .m_valid (rg_valid),
    .m_ready (rg_ready),
    .m_total (rg_total)
  );

  adcma_bar #(
    .PRIOR_SAMPLES (PRIOR_SAMPLES)
  ) u_bar (
    .clk     (clk),
    .rst_n   (rst_n),
    .thr     (thr_r),
    .s_valid (rg_valid),
    .s_ready (rg_ready),
    .s_total (rg_total),
    .m_valid (out_valid),
    .m_ready (!out_stall),
    .m_avg   (out_average_millivolts),
    .m_mask  (out_led_mask)
  );

  assign cfg_low_we = cfg_we && (cfg_index == CFG_THR_LOW);
  assign mask_ok    = (out_led_mask == MASK_FOUR) || (out_led_mask == MASK_THREE) ||
                      (out_led_mask == MASK_TWO) || (out_led_mask == MASK_ONE);

  `ADCMA_ASSERT_NEXT(a_cfg_low_write, clk, rst_n, cfg_low_we, thr_r.low == $past(cfg_data))
  `ADCMA_ASSERT_NOW(a_mask_code, clk, rst_n, out_valid, mask_ok)
  `ADCMA_ASSERT_NOW(a_avg_range, clk, rst_n, out_valid, out_average_millivolts <= MV_W'(MV_MAX))

endmodule

FILE: src/adcma_conv.sv
// raw adc word to millivolts, holding the last good value on bad samples
// depends on adcma_pkg
module adcma_conv import adcma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [RAW_W-1:0]  s_raw,
  input  logic              s_failed,
  output logic              m_valid,
  input  logic              m_ready,
  output logic [MV_W-1:0]   m_cur
);

  logic             a_v_r, b_v_r, c_v_r;
  logic             a_rdy, b_rdy, c_rdy;
  logic [RAW_W-1:0] raw_r;
  logic             failed_r;
  logic [X_W-1:0]   x_r;
  logic             good_r;
  logic [MV_W-1:0]  cur_r, last_mv_r;

  logic             good;
  logic [X_W-1:0]   x;
  logic [X_W:0]     xs;
  logic [MV_W-1:0]  q;
  logic [X_W-1:0]   qx, qm, rem;
  logic [MV_W-1:0]  mv, cur;

  assign c_rdy   = !c_v_r || m_ready;
  assign b_rdy   = !b_v_r || c_rdy;
  assign a_rdy   = !a_v_r || b_rdy;
  assign s_ready = a_rdy;

  // scale by 3000 then divide by 1023 via 1024 with one correction step
  always_comb begin
    good = !failed_r && (raw_r <= ADC_MAX);
    x    = X_W'(raw_r[ADC_BITS-1:0]) * FULL_SCALE_MV;
    xs   = {1'b0, x_r} + (X_W+1)'(x_r >> ADC_BITS);
    q    = MV_W'(xs >> ADC_BITS);
    qx   = X_W'(q);
    qm   = (qx << ADC_BITS) - qx;
    rem  = x_r - qm;
    mv   = q + MV_W'(rem >= X_W'(ADC_MAX));
    cur  = good_r ? mv : last_mv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      last_mv_r <= MV_RESET;
    end else begin
      if (a_rdy) begin
        a_v_r <= s_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
      if (c_rdy) begin
        c_v_r <= b_v_r;
      end
      if (b_v_r && c_rdy) begin
        last_mv_r <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && a_rdy) begin
      raw_r    <= s_raw;
      failed_r <= s_failed;
    end
    if (a_v_r && b_rdy) begin
      x_r    <= x;
      good_r <= good;
    end
    if (b_v_r && c_rdy) begin
      cur_r <= cur;
    end
  end

  assign m_valid = c_v_r;
  assign m_cur   = cur_r;

endmodule

FILE: src/adcma_ring.sv
// history shift line, running sum and fill count; emits the window total
// depends on adcma_pkg
module adcma_ring import adcma_pkg::*; #(
  parameter  int unsigned PRIOR_SAMPLES = 9,
  localparam int unsigned TOT_W = $clog2((PRIOR_SAMPLES + 1) * MV_MAX + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [MV_W-1:0]  s_cur,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [TOT_W-1:0] m_total
);

  localparam int unsigned SUM_W  = $clog2(PRIOR_SAMPLES * MV_MAX + 1);
  localparam int unsigned FILL_W = $clog2(PRIOR_SAMPLES + 1);

  logic [MV_W-1:0]   tap_r [PRIOR_SAMPLES];
  logic [SUM_W-1:0]  sum_r;
  logic [FILL_W-1:0] fill_r;
  logic              d_v_r;
  logic [TOT_W-1:0]  total_r;

  logic              full, fire;
  logic [MV_W-1:0]   oldest;
  logic [TOT_W-1:0]  total;

  assign full    = (fill_r == FILL_W'(PRIOR_SAMPLES));
  assign s_ready = !d_v_r || m_ready;
  assign fire    = s_valid && s_ready;
  assign oldest  = tap_r[PRIOR_SAMPLES-1];
  assign total   = TOT_W'(sum_r) + TOT_W'(s_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
      d_v_r  <= 1'b0;
    end else begin
      if (s_ready) begin
        d_v_r <= fire && full;
      end
      if (fire) begin
        if (full) begin
          sum_r <= sum_r + SUM_W'(s_cur) - SUM_W'(oldest);
        end else begin
          sum_r  <= sum_r + SUM_W'(s_cur);
          fill_r <= fill_r + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tap_r[0] <= s_cur;
      for (int i = 1; i < PRIOR_SAMPLES; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
      total_r <= total;
    end
  end

  assign m_valid = d_v_r;
  assign m_total = total_r;

endmodule

FILE: src/adcma_bar.sv
// window total to mean by reciprocal multiply, then threshold bar mask
// depends on adcma_pkg
module adcma_bar import adcma_pkg::*; #(
  parameter  int unsigned PRIOR_SAMPLES = 9,
  localparam int unsigned TOT_W = $clog2((PRIOR_SAMPLES + 1) * MV_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  thr_t              thr,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [TOT_W-1:0]  s_total,
  output logic              m_valid,
  input  logic              m_ready,
  output logic [MV_W-1:0]   m_avg,
  output logic [MASK_W-1:0] m_mask
);

  localparam int unsigned DIV    = PRIOR_SAMPLES + 1;
  localparam int unsigned SH     = TOT_W + $clog2(DIV);
  localparam int unsigned RCP_W  = SH + 1;
  localparam int unsigned RECIP  = ((1 << SH) + DIV - 1) / DIV;
  localparam int unsigned PROD_W = TOT_W + RCP_W;

  logic              e_v_r, o_v_r;
  logic              e_rdy, o_rdy;
  logic [MV_W-1:0]   avg_r, avg_out_r;
  logic [MASK_W-1:0] mask_out_r;

  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]   avg;
  logic [MASK_W-1:0] mask;

  assign o_rdy   = !o_v_r || m_ready;
  assign e_rdy   = !e_v_r || o_rdy;
  assign s_ready = e_rdy;

  assign prod = PROD_W'(s_total) * PROD_W'(RCP_W'(RECIP));
  assign avg  = prod[SH +: MV_W];

  always_comb begin
    priority if (avg_r < thr.low) begin
      mask = MASK_FOUR;
    end else if (avg_r < thr.mid) begin
      mask = MASK_THREE;
    end else if (avg_r < thr.high) begin
      mask = MASK_TWO;
    end else begin
      mask = MASK_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (e_rdy) begin
        e_v_r <= s_valid;
      end
      if (o_rdy) begin
        o_v_r <= e_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && e_rdy) begin
      avg_r <= avg;
    end
    if (e_v_r && o_rdy) begin
      avg_out_r  <= avg_r;
      mask_out_r <= mask;
    end
  end

  assign m_valid = o_v_r;
  assign m_avg   = avg_out_r;
  assign m_mask  = mask_out_r;

endmodule

FILE: bench/tb_top.sv
// self-checking bench for adc_moving_average_bar_level: converts and averages words, checks levels
// depends on adcma_pkg and the adc_moving_average_bar_level rtl
module tb_top;
  import adcma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRIOR_SAMPLES = 9;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [MV_W-1:0]   avg;
    logic [MASK_W-1:0] mask;
  } level_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [RAW_W-1:0]     in_raw_sample = '0;
  logic                 in_read_failed = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MV_W-1:0]      out_average_millivolts;
  logic [MASK_W-1:0]    out_led_mask;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;

  // predictor state
  logic [THR_W-1:0] thr_low = THR_LOW_RESET;
  logic [THR_W-1:0] thr_mid = THR_MID_RESET;
  logic [THR_W-1:0] thr_high = THR_HIGH_RESET;
  logic [MV_W-1:0]  last_mv = MV_RESET;
  logic [MV_W-1:0]  mv_hist [PRIOR_SAMPLES];
  int unsigned      hist_pos = 0;
  int unsigned      hist_fill = 0;
  int unsigned      hist_sum = 0;
  level_t           level_q [$];
  level_t           level_exp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  adc_moving_average_bar_level dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_raw_sample          (in_raw_sample),
    .in_read_failed         (in_read_failed),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_average_millivolts (out_average_millivolts),
    .out_led_mask           (out_led_mask),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic predict_level(input logic [RAW_W-1:0] raw, input logic failed);
    level_t      lv;
    int unsigned avg;
    if (!failed && raw <= ADC_MAX) begin
      last_mv = MV_W'((32'(raw) * 32'd3000) / 32'd1023);
    end
    if (hist_fill < PRIOR_SAMPLES) begin
      hist_sum += last_mv;
      hist_fill++;
    end else begin
      avg = (hist_sum + last_mv) / (PRIOR_SAMPLES + 1);
      lv.avg = MV_W'(avg);
      if (avg < thr_low) lv.mask = MASK_FOUR;
      else if (avg < thr_mid) lv.mask = MASK_THREE;
      else if (avg < thr_high) lv.mask = MASK_TWO;
      else lv.mask = MASK_ONE;
      level_q.push_back(lv);
      hist_sum = hist_sum - mv_hist[hist_pos] + last_mv;
    end
    mv_hist[hist_pos] = last_mv;
    hist_pos = (hist_pos + 1) % PRIOR_SAMPLES;
  endtask

  task automatic send_word(input logic [RAW_W-1:0] raw, input logic failed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_sample <= raw;
    in_read_failed <= failed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_level(raw, failed);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_THR_LOW:  thr_low = data;
      CFG_THR_MID:  thr_mid = data;
      CFG_THR_HIGH: thr_high = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] mid,
                                input logic [THR_W-1:0] hi);
    drain();
    write_reg(CFG_THR_LOW, lo);
    write_reg(CFG_THR_MID, mid);
    write_reg(CFG_THR_HIGH, hi);
  endtask

  // fill phase, failed and out-of-range words before and after a good one
  task automatic test_conversion();
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'd1023, 1'b0);
    send_word(16'd1024, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(16'd512, 1'b0);
    send_word(16'd1, 1'b0);
    send_word(16'd1022, 1'b0);
    send_word(16'd1023, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'd341, 1'b1);
  endtask

  task automatic test_thresholds();
    set_thresholds('0, '0, '0);
    send_word(16'd0, 1'b0);
    send_word(16'd1023, 1'b0);
    set_thresholds('1, '1, '1);
    send_word(16'd1023, 1'b0);
    send_word(16'd700, 1'b0);
    // unordered: first low above mid, then mid above high
    set_thresholds(12'd4095, 12'd0, 12'd0);
    send_word(16'd1023, 1'b0);
    set_thresholds(12'd0, 12'd4095, 12'd0);
    send_word(16'd1023, 1'b0);
    set_thresholds(12'd0, 12'd0, 12'd4095);
    send_word(16'd1023, 1'b0);
    drain();
    write_reg(CFG_SPARE, 12'd0);
    write_reg(CFG_SPARE, 12'hFFF);
    send_word(16'd0, 1'b0);
    send_word(16'd1023, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_pressure();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_hold = 300;
    for (int k = 0; k < 60; k++) send_word(RAW_W'($urandom_range(1023)), 1'b0);
  endtask

  task automatic test_random(input int count, input int in_pct, input int out_pct);
    int level;
    int v;
    int pick;
    drain();
    send_idle_pct = in_pct;
    recv_stall_pct = out_pct;
    level = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 16 == 0) begin
        pick = $urandom_range(7);
        level = (pick == 0) ? 0 : (pick == 1) ? 1023 : int'($urandom_range(1023));
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word(RAW_W'($urandom), 1'b1);
      end else if (pick < 16) begin
        send_word(RAW_W'($urandom_range(65535, 1024)), 1'b0);
      end else begin
        v = level + int'($urandom_range(40)) - 20;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        send_word(RAW_W'(v), 1'b0);
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (level_q.size() == 0) begin
        $error("unexpected result word: average_millivolts %0d led_mask %0d",
               out_average_millivolts, out_led_mask);
        fail_count++;
      end else begin
        level_exp = level_q.pop_front();
        if (out_average_millivolts !== level_exp.avg) begin
          $error("average_millivolts: expected %0d, got %0d", level_exp.avg,
                 out_average_millivolts);
          fail_count++;
        end
        if (out_led_mask !== level_exp.mask) begin
          $error("led_mask: expected %0d, got %0d", level_exp.mask, out_led_mask);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_conversion();
    test_thresholds();
    test_pressure();
    set_thresholds(THR_LOW_RESET, THR_MID_RESET, THR_HIGH_RESET);
    test_random(400, 0, 0);
    set_thresholds(12'd500, 12'd1500, 12'd2600);
    test_random(400, 48, 0);
    set_thresholds(12'd2500, 12'd800, 12'd1700);
    test_random(400, 0, 48);
    set_thresholds(12'd0, 12'd3000, 12'd4095);
    test_random(350, 33, 33);
    drain();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: adc_moving_average_bar_level.f
+incdir+src
src/adcma_pkg.sv
src/adcma_conv.sv
src/adcma_ring.sv
src/adcma_bar.sv
src/adc_moving_average_bar_level.sv
bench/tb_top.sv
